// File: rtl/biot_savart_segment_field_unit_assert.svh
// ----------------------------------------------------------------------------
// biot-savart segment field unit: assertion macros
// concurrent checks that are compiled away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BIOT_SAVART_SEGMENT_FIELD_UNIT_ASSERT_SVH
`define BIOT_SAVART_SEGMENT_FIELD_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BSSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bssf assertion failed");
// next-cycle implication
`define BSSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bssf assertion failed");
`else
`define BSSF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BSSF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/bssf_pkg.sv
// ----------------------------------------------------------------------------
// bssf_pkg
// item types, inter-stage structs and fixed sizes of the segment field unit
// ----------------------------------------------------------------------------
`default_nettype none
package bssf_pkg;

  // one root bit per stage, one quotient bit per stage
  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned DIV_STEPS   = 32;

  // segment and field point, signed q8.24 metres
  typedef struct packed {
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;
    logic signed [31:0] field_pt_x;
    logic signed [31:0] field_pt_y;
    logic signed [31:0] field_pt_z;
  } bssf_in_t;

  // field components, signed q16.16 per metre, and flags
  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic               zero_distance;
    logic               saturated;
  } bssf_out_t;

  // cross product, squared length and scale, carried through the root pipe
  typedef struct packed {
    logic [2:0][63:0] c;
    logic [61:0]      s;
    logic [5:0]       blen;
  } bssf_mid_t;

  // numerator magnitudes and signs for the divider
  typedef struct packed {
    logic [2:0][62:0] mag;
    logic [2:0]       neg;
    logic [5:0]       blen;
  } bssf_num_t;

  // quotients and status out of the divider
  typedef struct packed {
    logic [2:0][31:0] q;
    logic [2:0]       over;
    logic [2:0]       neg;
    logic             zero;
  } bssf_quo_t;

endpackage
`default_nettype wire

// File: rtl/bssf_sqrt.sv
// ----------------------------------------------------------------------------
// bssf_sqrt
// pipelined integer square root, one root bit per stage, side data carried
// ----------------------------------------------------------------------------
`default_nettype none
`include "biot_savart_segment_field_unit_assert.svh"
module bssf_sqrt (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                vld_in,
  input  wire bssf_pkg::bssf_mid_t mid_in,
  output logic                     vld_out,
  output bssf_pkg::bssf_mid_t      mid_out,
  output logic [30:0]              root_out
);

  localparam int unsigned NS = bssf_pkg::SQRT_STAGES;

  logic                v_r   [NS];
  logic [61:0]         x_r   [NS];
  logic [61:0]         res_r [NS];
  bssf_pkg::bssf_mid_t m_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);

    logic [61:0]         x_i;
    logic [61:0]         res_i;
    logic                v_i;
    bssf_pkg::bssf_mid_t m_i;
    logic [62:0]         trial;
    logic                ge;
    logic [61:0]         x_nxt;
    logic [61:0]         res_nxt;

    if (k == 0) begin : g_first
      assign x_i   = mid_in.s;
      assign res_i = '0;
      assign v_i   = vld_in;
      assign m_i   = mid_in;
    end else begin : g_next
      assign x_i   = x_r[k-1];
      assign res_i = res_r[k-1];
      assign v_i   = v_r[k-1];
      assign m_i   = m_r[k-1];
    end

    // try the next root bit against the remainder
    assign trial   = {1'b0, res_i} + {1'b0, BIT};
    assign ge      = {1'b0, x_i} >= trial;
    assign x_nxt   = ge ? (x_i - trial[61:0]) : x_i;
    assign res_nxt = ge ? ((res_i >> 1) + BIT) : (res_i >> 1);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_nxt;
        res_r[k] <= res_nxt;
        m_r[k]   <= m_i;
      end
    end
  end

  assign vld_out  = v_r[NS-1];
  assign mid_out  = m_r[NS-1];
  assign root_out = res_r[NS-1][30:0];

  // root is the floor of the square root of the carried radicand
  `BSSF_ASSERT_IMP(a_root_low, clk, rst_n, vld_out,
    64'(root_out) * 64'(root_out) <= 64'(mid_out.s))
  `BSSF_ASSERT_IMP(a_root_high, clk, rst_n, vld_out,
    (64'(root_out) + 64'd1) * (64'(root_out) + 64'd1) > 64'(mid_out.s))

endmodule
`default_nettype wire

// File: rtl/bssf_div.sv
// ----------------------------------------------------------------------------
// bssf_div
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module bssf_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                vld_in,
  input  wire bssf_pkg::bssf_num_t num_in,
  input  wire logic [92:0]         den_in,
  output logic                     vld_out,
  output bssf_pkg::bssf_quo_t      quo_out
);

  localparam int unsigned NS = bssf_pkg::DIV_STEPS;

  // numerator scaling stage
  logic              vx_r;
  logic [2:0][130:0] xs_r;
  logic [92:0]       denx_r;
  logic [2:0]        negx_r;
  logic              zerox_r;
  logic [2:0][130:0] xs_nxt;
  logic [6:0]        sa;

  // scale |c| by 2^(70 - 2*blen), i.e. 2^(e - 32)
  always_comb begin
    sa = 7'd70 - {num_in.blen, 1'b0};
    for (int k = 0; k < 3; k++) begin
      xs_nxt[k] = {68'b0, num_in.mag[k]} << sa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= 1'b0;
    end else if (en) begin
      vx_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r    <= xs_nxt;
      denx_r  <= den_in;
      negx_r  <= num_in.neg;
      zerox_r <= (num_in.blen == 6'd0);
    end
  end

  // overflow test and long division stages
  logic             v_r    [NS+1];
  logic [2:0][92:0] rem_r  [NS+1];
  logic [2:0][31:0] q_r    [NS+1];
  logic [92:0]      den_r  [NS+1];
  logic [2:0]       over_r [NS+1];
  logic [2:0]       neg_r  [NS+1];
  logic             zero_r [NS+1];

  logic [2:0]       over_nxt;

  // quotient of 2^32 or more when the scaled numerator reaches the divisor
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      over_nxt[k] = (xs_r[k][130:93] != 38'd0) || (xs_r[k][92:0] >= denx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[0][k] <= xs_r[k][92:0];
      end
      q_r[0]    <= '0;
      den_r[0]  <= denx_r;
      over_r[0] <= over_nxt;
      neg_r[0]  <= negx_r;
      zero_r[0] <= zerox_r;
    end
  end

  for (genvar t = 1; t <= NS; t++) begin : g_step
    logic [2:0][92:0] rem_nxt;
    logic [2:0][31:0] q_nxt;

    // double the remainder, subtract the divisor where it fits
    always_comb begin
      logic [93:0] rem2;
      logic [93:0] diff;
      logic        ge;
      for (int k = 0; k < 3; k++) begin
        rem2       = {rem_r[t-1][k], 1'b0};
        diff       = rem2 - {1'b0, den_r[t-1]};
        ge         = rem2 >= {1'b0, den_r[t-1]};
        rem_nxt[k] = ge ? diff[92:0] : rem2[92:0];
        q_nxt[k]   = {q_r[t-1][k][30:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[t] <= 1'b0;
      end else if (en) begin
        v_r[t] <= v_r[t-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[t]  <= rem_nxt;
        q_r[t]    <= q_nxt;
        den_r[t]  <= den_r[t-1];
        over_r[t] <= over_r[t-1];
        neg_r[t]  <= neg_r[t-1];
        zero_r[t] <= zero_r[t-1];
      end
    end
  end

  assign vld_out      = v_r[NS];
  assign quo_out.q    = q_r[NS];
  assign quo_out.over = over_r[NS];
  assign quo_out.neg  = neg_r[NS];
  assign quo_out.zero = zero_r[NS];

endmodule
`default_nettype wire

// File: rtl/bssf_skid.sv
// ----------------------------------------------------------------------------
// bssf_skid
// output register with one skid entry, so the pipeline stall is registered
// ----------------------------------------------------------------------------
`default_nettype none
`include "biot_savart_segment_field_unit_assert.svh"
module bssf_skid (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  input  wire bssf_pkg::bssf_out_t up_data,
  output logic                     up_stall,
  output logic                     dn_valid,
  output bssf_pkg::bssf_out_t      dn_data,
  input  wire logic                dn_stall
);

  logic                out_valid_r, out_valid_nxt;
  bssf_pkg::bssf_out_t out_data_r, out_data_nxt;
  logic                skid_full_r, skid_full_nxt;
  bssf_pkg::bssf_out_t skid_data_r, skid_data_nxt;
  logic                up_acc;

  assign up_acc = up_valid && !skid_full_r;

  // refill the output from the skid entry first, else from upstream
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_full_nxt = skid_full_r;
    skid_data_nxt = skid_data_r;
    if (!out_valid_r || !dn_stall) begin
      if (skid_full_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = skid_data_r;
        skid_full_nxt = 1'b0;
      end else begin
        out_valid_nxt = up_acc;
        out_data_nxt  = up_data;
      end
    end else if (up_acc) begin
      skid_full_nxt = 1'b1;
      skid_data_nxt = up_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign up_stall = skid_full_r;
  assign dn_valid = out_valid_r;
  assign dn_data  = out_data_r;

  // the skid entry only fills behind a held output item
  `BSSF_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_full_r, out_valid_r)
  `BSSF_ASSERT_NXT(a_skid_holds, clk, rst_n, skid_full_r && dn_stall, skid_full_r)

endmodule
`default_nettype wire

// File: rtl/biot_savart_segment_field_unit.sv
// throughput: one item per cycle while the skid entry is not full
// 31 root stages and 32 long-division step stages set depth
// out_stall holds the whole pipeline once the skid fills behind a refused result
// reset: synchronous active-low rst_n clears all valid bits; no clearing pass
// ----------------------------------------------------------------------------
// biot_savart_segment_field_unit
// (segment x r) / |r|^3 for a current segment and a field point, midpoint rule
// ----------------------------------------------------------------------------
`default_nettype none
`include "biot_savart_segment_field_unit_assert.svh"
module biot_savart_segment_field_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bssf_pkg::bssf_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bssf_pkg::bssf_out_t     out_data
);

  logic en;
  logic skid_stall;

  assign en       = !skid_stall;
  assign in_stall = skid_stall;

  // ---- stage 1: segment vector and doubled offset from the midpoint ----
  logic [2:0][31:0] pa, pb, pp;
  logic             v1_r;
  logic [2:0][32:0] d1_r, d1_nxt;
  logic [2:0][33:0] r1_r, r1_nxt;

  assign pa = {in_data.seg_start_x, in_data.seg_start_y, in_data.seg_start_z};
  assign pb = {in_data.seg_end_x, in_data.seg_end_y, in_data.seg_end_z};
  assign pp = {in_data.field_pt_x, in_data.field_pt_y, in_data.field_pt_z};

  // packed index 2 is x, 0 is z; cross product below follows that order
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1_nxt[k] = {pb[k][31], pb[k]} - {pa[k][31], pa[k]};
      r1_nxt[k] = {pp[k][31], pp[k], 1'b0} - {{2{pa[k][31]}}, pa[k]}
                - {{2{pb[k][31]}}, pb[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= d1_nxt;
      r1_r <= r1_nxt;
    end
  end

  // ---- stage 2: magnitudes and bit length of the largest ----
  logic             v2_r;
  logic [2:0][32:0] d2_r;
  logic [2:0][33:0] mag2_r, mag2_nxt;
  logic [2:0]       neg2_r, neg2_nxt;
  logic [5:0]       blen2_r, blen2_nxt;
  logic [33:0]      mag_or;

  always_comb begin
    mag_or = '0;
    for (int k = 0; k < 3; k++) begin
      neg2_nxt[k] = r1_r[k][33];
      mag2_nxt[k] = r1_r[k][33] ? (34'd0 - r1_r[k]) : r1_r[k];
      mag_or      = mag_or | mag2_nxt[k];
    end
    blen2_nxt = '0;
    for (int i = 0; i < 34; i++) begin
      if (mag_or[i]) begin
        blen2_nxt = 6'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r    <= d1_r;
      mag2_r  <= mag2_nxt;
      neg2_r  <= neg2_nxt;
      blen2_r <= blen2_nxt;
    end
  end

  // ---- stage 3: normalise r so its largest component has 30 bits ----
  logic             v3_r;
  logic [2:0][32:0] d3_r;
  logic [2:0][30:0] rs3_r, rs3_nxt;
  logic [2:0][29:0] rm3_r, rm3_nxt;
  logic [5:0]       blen3_r;

  always_comb begin
    logic [33:0] tr;
    logic [63:0] tl;
    for (int k = 0; k < 3; k++) begin
      tr = mag2_r[k] >> (blen2_r - 6'd30);
      tl = {30'b0, mag2_r[k]} << (6'd30 - blen2_r);
      rm3_nxt[k] = (blen2_r > 6'd30) ? tr[29:0] : tl[29:0];
      rs3_nxt[k] = neg2_r[k] ? (31'd0 - {1'b0, rm3_nxt[k]}) : {1'b0, rm3_nxt[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r    <= d2_r;
      rs3_r   <= rs3_nxt;
      rm3_r   <= rm3_nxt;
      blen3_r <= blen2_r;
    end
  end

  // ---- stage 4: cross product terms and squares ----
  logic             v4_r;
  logic [2:0][63:0] pa4_r, pa4_nxt;
  logic [2:0][63:0] pb4_r, pb4_nxt;
  logic [2:0][59:0] sq4_r, sq4_nxt;
  logic [5:0]       blen4_r;

  // index 2 is x, 1 is y, 0 is z
  always_comb begin
    logic signed [63:0] p0, p1, p2, p3, p4, p5;
    p0 = $signed(d3_r[1]) * $signed(rs3_r[0]);
    p1 = $signed(d3_r[0]) * $signed(rs3_r[1]);
    p2 = $signed(d3_r[0]) * $signed(rs3_r[2]);
    p3 = $signed(d3_r[2]) * $signed(rs3_r[0]);
    p4 = $signed(d3_r[2]) * $signed(rs3_r[1]);
    p5 = $signed(d3_r[1]) * $signed(rs3_r[2]);
    pa4_nxt[2] = p0;
    pb4_nxt[2] = p1;
    pa4_nxt[1] = p2;
    pb4_nxt[1] = p3;
    pa4_nxt[0] = p4;
    pb4_nxt[0] = p5;
    for (int k = 0; k < 3; k++) begin
      sq4_nxt[k] = rm3_r[k] * rm3_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa4_r   <= pa4_nxt;
      pb4_r   <= pb4_nxt;
      sq4_r   <= sq4_nxt;
      blen4_r <= blen3_r;
    end
  end

  // ---- stage 5: cross product and squared length ----
  logic                v5_r;
  bssf_pkg::bssf_mid_t mid5_r, mid5_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mid5_nxt.c[k] = pa4_r[k] - pb4_r[k];
    end
    mid5_nxt.s    = {2'b0, sq4_r[0]} + {2'b0, sq4_r[1]} + {2'b0, sq4_r[2]};
    mid5_nxt.blen = blen4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid5_r <= mid5_nxt;
    end
  end

  // ---- root of the squared length ----
  logic                vsq;
  bssf_pkg::bssf_mid_t midsq;
  logic [30:0]         root;

  bssf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (v5_r),
    .mid_in   (mid5_r),
    .vld_out  (vsq),
    .mid_out  (midsq),
    .root_out (root)
  );

  // ---- stage 6: partial products of s * root, numerator magnitudes ----
  logic             v6_r;
  logic [61:0]      ph6_r, pl6_r;
  logic [2:0][62:0] cm6_r, cm6_nxt;
  logic [2:0]       neg6_r, neg6_nxt;
  logic [5:0]       blen6_r;

  always_comb begin
    logic [63:0] cm;
    for (int k = 0; k < 3; k++) begin
      neg6_nxt[k] = midsq.c[k][63];
      cm          = midsq.c[k][63] ? (64'd0 - midsq.c[k]) : midsq.c[k];
      cm6_nxt[k]  = cm[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= vsq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph6_r   <= midsq.s[61:31] * root;
      pl6_r   <= midsq.s[30:0] * root;
      cm6_r   <= cm6_nxt;
      neg6_r  <= neg6_nxt;
      blen6_r <= midsq.blen;
    end
  end

  // ---- stage 7: divisor s * root ----
  logic                v7_r;
  logic [92:0]         den7_r;
  bssf_pkg::bssf_num_t num7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den7_r      <= {ph6_r, 31'b0} + {31'b0, pl6_r};
      num7_r.mag  <= cm6_r;
      num7_r.neg  <= neg6_r;
      num7_r.blen <= blen6_r;
    end
  end

  // ---- divide by s * root ----
  logic                vdv;
  bssf_pkg::bssf_quo_t quo;

  bssf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (v7_r),
    .num_in  (num7_r),
    .den_in  (den7_r),
    .vld_out (vdv),
    .quo_out (quo)
  );

  // ---- final stage: sign, clamp and the zero distance case ----
  logic                vfin_r;
  bssf_pkg::bssf_out_t fin_r, fin_nxt;

  always_comb begin
    logic [2:0][31:0] val;
    logic             sat;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (quo.neg[k]) begin
        if (quo.over[k] || (quo.q[k] > 32'h8000_0000)) begin
          val[k] = 32'h8000_0000;
          sat    = 1'b1;
        end else begin
          val[k] = 32'd0 - quo.q[k];
        end
      end else if (quo.over[k] || quo.q[k][31]) begin
        val[k] = 32'h7FFF_FFFF;
        sat    = 1'b1;
      end else begin
        val[k] = quo.q[k];
      end
    end
    if (quo.zero) begin
      fin_nxt.field_x       = '0;
      fin_nxt.field_y       = '0;
      fin_nxt.field_z       = '0;
      fin_nxt.zero_distance = 1'b1;
      fin_nxt.saturated     = 1'b0;
    end else begin
      fin_nxt.field_x       = $signed(val[2]);
      fin_nxt.field_y       = $signed(val[1]);
      fin_nxt.field_z       = $signed(val[0]);
      fin_nxt.zero_distance = 1'b0;
      fin_nxt.saturated     = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vfin_r <= 1'b0;
    end else if (en) begin
      vfin_r <= vdv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // ---- output register and skid entry ----
  bssf_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vfin_r),
    .up_data  (fin_r),
    .up_stall (skid_stall),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_stall (out_stall)
  );

  // a zero distance item leaves with zero components and no clamp
  `BSSF_ASSERT_IMP(a_zero_result, clk, rst_n, out_valid && out_data.zero_distance,
    out_data.field_x == 32'sd0 && out_data.field_y == 32'sd0 &&
    out_data.field_z == 32'sd0 && !out_data.saturated)

endmodule
`default_nettype wire

// File: verif/tb_biot_savart_segment_field_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment field unit testbench
// drives segment and field point items through the valid/stall handshake,
// predicts (segment x r) / |r|^3 with exact integer arithmetic and compares
// every result in order, with random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

// expected field results, computed as items are accepted
class field_scoreboard;
  bssf_pkg::bssf_out_t expected_q[$];
  int mismatches;
  int checked;
  int zero_hits;
  int sat_hits;

  function new();
    mismatches = 0;
    checked    = 0;
    zero_hits  = 0;
    sat_hits   = 0;
  endfunction

  static function longint unsigned abs64(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // one clamped signed q16.16 component of c * 2^e / den
  static function logic [31:0] scaled_quotient(longint c, int e, logic [127:0] den,
                                               ref logic sat);
    logic [255:0] num;
    logic [255:0] quo;
    num = {192'd0, abs64(c)} << e;
    quo = num / {128'd0, den};
    if (c < 0) begin
      if (quo > 256'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-quo);
    end
    if (quo > 256'h7fff_ffff) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    return quo[31:0];
  endfunction

  static function bssf_pkg::bssf_out_t field_of(bssf_pkg::bssf_in_t x);
    bssf_pkg::bssf_out_t res;
    longint st[3], en[3], pt[3];
    longint d[3], r2[3], rs[3], c[3];
    longint unsigned mx, mk, s, root;
    logic [127:0] den;
    int blen, sh;
    logic sat;
    st[0] = longint'(x.seg_start_x); st[1] = longint'(x.seg_start_y);
    st[2] = longint'(x.seg_start_z);
    en[0] = longint'(x.seg_end_x); en[1] = longint'(x.seg_end_y);
    en[2] = longint'(x.seg_end_z);
    pt[0] = longint'(x.field_pt_x); pt[1] = longint'(x.field_pt_y);
    pt[2] = longint'(x.field_pt_z);
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      d[k]  = en[k] - st[k];
      r2[k] = 2 * pt[k] - st[k] - en[k];
      if (abs64(r2[k]) > mx) mx = abs64(r2[k]);
    end
    res = '0;
    // field point sits on the midpoint
    if (mx == 0) begin
      res.zero_distance = 1'b1;
      return res;
    end
    blen = 0;
    while ((mx >> blen) != 0) blen++;
    sh = blen - 30;
    // normalise r so its largest component has 30 bits
    for (int k = 0; k < 3; k++) begin
      mk = abs64(r2[k]);
      if (sh > 0) mk = mk >> sh;
      else mk = mk << (-sh);
      rs[k] = (r2[k] < 0) ? -longint'(mk) : longint'(mk);
    end
    c[0] = d[1] * rs[2] - d[2] * rs[1];
    c[1] = d[2] * rs[0] - d[0] * rs[2];
    c[2] = d[0] * rs[1] - d[1] * rs[0];
    s = rs[0] * rs[0] + rs[1] * rs[1] + rs[2] * rs[2];
    root = int_sqrt(s);
    den = {64'd0, s} * {64'd0, root};
    sat = 1'b0;
    res.field_x = scaled_quotient(c[0], 42 - 2 * sh, den, sat);
    res.field_y = scaled_quotient(c[1], 42 - 2 * sh, den, sat);
    res.field_z = scaled_quotient(c[2], 42 - 2 * sh, den, sat);
    res.saturated = sat;
    return res;
  endfunction

  function void note_segment(bssf_pkg::bssf_in_t x);
    expected_q.push_back(field_of(x));
  endfunction

  function void check_field(bssf_pkg::bssf_out_t got);
    bssf_pkg::bssf_out_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %p", got);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (want.zero_distance) zero_hits++;
    if (want.saturated) sat_hits++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp x=%h y=%h z=%h zd=%b sat=%b, got x=%h y=%h z=%h zd=%b sat=%b",
                 want.field_x, want.field_y, want.field_z, want.zero_distance,
                 want.saturated, got.field_x, got.field_y, got.field_z,
                 got.zero_distance, got.saturated);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_biot_savart_segment_field_unit;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bssf_pkg::bssf_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bssf_pkg::bssf_out_t out_data;

  field_scoreboard sb;
  int unsigned cycle_cnt;
  int unsigned sent;

  biot_savart_segment_field_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // quiet stretch: no idling on either side
  function automatic bit quiet_window();
    return (cycle_cnt >= 300 && cycle_cnt < 800);
  endfunction

  // cycle counter
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // accepted input items
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_segment(in_data);
  end

  // accepted result items
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_field(out_data);
  end

  // receiver stalls at random
  always @(negedge clk) begin
    if (!rst_n || quiet_window()) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 13);
  end

  // present one item and hold it until accepted
  task automatic send_segment(bssf_pkg::bssf_in_t x);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall);
    sent++;
    if (!quiet_window() && $urandom_range(99) < 15) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] coord_rand();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(65535)) - 32768) <<< $urandom_range(24);
      2:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(33554431)) - 16777216);
    endcase
  endfunction

  // random segment; often with the field point close to the midpoint
  function automatic bssf_pkg::bssf_in_t random_segment();
    bssf_pkg::bssf_in_t x;
    logic [31:0] off;
    x.seg_start_x = coord_rand(); x.seg_start_y = coord_rand();
    x.seg_start_z = coord_rand(); x.seg_end_x = coord_rand();
    x.seg_end_y = coord_rand(); x.seg_end_z = coord_rand();
    x.field_pt_x = coord_rand(); x.field_pt_y = coord_rand();
    x.field_pt_z = coord_rand();
    if ($urandom_range(3) == 0) begin
      off = 32'($signed($urandom_range(15)) - 8);
      x.field_pt_x = 32'((longint'(x.seg_start_x) + longint'(x.seg_end_x)) >>> 1) + off;
      x.field_pt_y = 32'((longint'(x.seg_start_y) + longint'(x.seg_end_y)) >>> 1);
      x.field_pt_z = 32'((longint'(x.seg_start_z) + longint'(x.seg_end_z)) >>> 1)
                     + 32'($urandom_range(2));
    end
    return x;
  endfunction

  function automatic bssf_pkg::bssf_in_t make_segment(logic [31:0] sx, sy, sz,
                                                      ex, ey, ez, px, py, pz);
    bssf_pkg::bssf_in_t x;
    x = '{sx, sy, sz, ex, ey, ez, px, py, pz};
    return x;
  endfunction

  // stimulus
  initial begin
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0100_0000;
    sb = new();
    sent      = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero distance, extremes, saturation, unit geometry
    send_segment('0);
    send_segment(make_segment(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send_segment(make_segment(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    send_segment(make_segment(MINV, 0, 0, MAXV, 0, 0, 0, 1, 0));
    send_segment(make_segment(MINV, 0, 0, MAXV, 0, 0, 0, -1, 0));
    send_segment(make_segment(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MINV));
    send_segment(make_segment(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV));
    send_segment(make_segment(0, 0, 0, ONE, 0, 0, 32'h0080_0000, ONE, 0));
    send_segment(make_segment(0, 0, 0, 0, ONE, 0, ONE, 32'h0080_0000, 0));
    send_segment(make_segment(0, 0, 0, 0, 0, ONE, 0, -ONE, 32'h0080_0000));
    send_segment(make_segment(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0));
    send_segment(make_segment(-ONE, 0, 0, ONE, 0, 0, 0, 0, 0));
    send_segment(make_segment(0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_segment(make_segment(0, 0, 0, MAXV, MAXV, 0, 0, 0, 1));
    send_segment(make_segment(MINV, MINV, 0, MAXV, MAXV, 0, 0, 0, -1));
    send_segment(make_segment(0, 0, 0, 2, 2, 2, 1, 1, 1));
    send_segment(make_segment(1, 0, 0, 0, 0, 0, 0, 0, MAXV));
    send_segment(make_segment(0, MAXV, 0, 0, MINV, 0, MAXV, 0, MINV));

    // random items
    for (int i = 0; i < 1250; i++) begin
      if (i == 600) drain_results();
      send_segment(random_segment());
    end

    drain_results();
    repeat (150) @(posedge clk);
    $display("%0d items sent, %0d results checked (%0d at the midpoint, %0d clamped)",
             sent, sb.checked, sb.zero_hits, sb.sat_hits);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("biot_savart_segment_field_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("biot_savart_segment_field_unit verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #4ms;
    $display("timeout");
    $display("biot_savart_segment_field_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire
